// ===== hw/rtl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg: shared types and constants for the GC content ratio block
//   Payload structs for the symbol and result channels, base codes and the
//   one-hot sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    // Width of the fixed-point result
    localparam int RATIO_BITS = 48;

    // ASCII codes of the counted bases (uppercase only)
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    // One symbol transfer
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } gcr_in_t;

    // One result transfer
    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  divisor_zero;
        logic                  saturated;
    } gcr_out_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } gcr_state_t;

endpackage : gcr_pkg

`default_nettype wire

// ===== hw/rtl/gc_content_ratio_top.sv =====
// ----------------------------------------------------------------------------
// gc_content_ratio_top: GC content of a nucleotide sequence
//   Counts uppercase A/C/G/T bytes in saturating counters and, on the symbol
//   marked last, divides with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Symbols are taken one per clock while counting. The symbol marked last is
// counted, then the block holds in_stall high while it forms numerator and
// denominator (ST_SETUP), makes COUNT_WIDTH + FRACTION_BITS + 1 quotient
// steps through the one shared subtractor of the restoring divider (ST_DIV),
// and places the result in the output register (ST_DONE). A zero divisor
// skips the quotient steps. ST_DONE waits while the output register still
// holds an earlier result that out_stall keeps back.
// The output register frees the symbol side: counting of the next sequence
// goes on while a result waits for out_stall to drop. Mode bit 1 (set
// via cfg_write/cfg_data) gives (G+C)/(A+C+G+T), 0 gives (A+T)/(G+C),
// both with FRACTION_BITS fraction bits, truncated and saturated to 48 bits.
`default_nettype none

module gc_content_ratio_top
    import gcr_pkg::*;
#(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    // configuration
    input  wire logic     cfg_write,
    input  wire logic     cfg_data,
    // symbol channel
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire gcr_in_t  in_data,
    // result channel
    output logic          out_valid,
    input  wire logic     out_stall,
    output gcr_out_t      out_data
);

    localparam int NUMW  = COUNT_WIDTH + 1;          // numerator width
    localparam int DENW  = COUNT_WIDTH + 2;          // denominator width
    localparam int DIVW  = NUMW + FRACTION_BITS;     // dividend / quotient width
    localparam int QEXT  = (DIVW > RATIO_BITS) ? DIVW : RATIO_BITS;
    localparam int STEPW = $clog2(DIVW + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    gcr_state_t             state_reg, state_next;
    logic                   mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [4];
    logic [COUNT_WIDTH-1:0] cnt_next [4];
    logic                   ovf_reg, ovf_next;
    logic [STEPW-1:0]       step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    logic [DIVW-1:0]        dvd_reg, dvd_next;
    logic [DENW-1:0]        den_reg, den_next;
    logic [DENW-1:0]        rem_reg, rem_next;
    logic                   dz_reg, dz_next;
    logic                   sat_reg, sat_next;
    gcr_out_t               res_reg, res_next;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic                   in_xfer;
    logic                   out_xfer;
    logic                   slot_free;
    logic [3:0]             hit;
    logic [COUNT_WIDTH-1:0] cnt_inc [4];
    logic [NUMW-1:0]        sum_at, sum_gc;
    logic [DENW-1:0]        sum_all;
    logic [DENW:0]          rem_trial, rem_diff;
    logic                   rem_ge;
    logic [QEXT-1:0]        quot_ext;
    logic                   clip;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // base decode: index 0 A, 1 C, 2 G, 3 T
    assign hit[0] = in_xfer && (in_data.symbol == CHAR_A);
    assign hit[1] = in_xfer && (in_data.symbol == CHAR_C);
    assign hit[2] = in_xfer && (in_data.symbol == CHAR_G);
    assign hit[3] = in_xfer && (in_data.symbol == CHAR_T);

    // saturating increments
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cnt_inc[i] = (cnt_reg[i] != COUNT_MAX) ? cnt_reg[i] + 1'b1 : cnt_reg[i];
        end
    end

    // operand sums
    assign sum_at  = NUMW'(cnt_reg[0]) + NUMW'(cnt_reg[3]);
    assign sum_gc  = NUMW'(cnt_reg[1]) + NUMW'(cnt_reg[2]);
    assign sum_all = DENW'(sum_at) + DENW'(sum_gc);

    // one restoring step: bring down the next dividend bit, trial subtract
    assign rem_trial = {rem_reg, dvd_reg[DIVW-1]};
    assign rem_diff  = rem_trial - {1'b0, den_reg};
    assign rem_ge    = !rem_diff[DENW];

    // quotient sits in dvd_reg after the last step
    assign quot_ext = QEXT'(dvd_reg);
    assign clip     = |(quot_ext >> RATIO_BITS);

    // ------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = cfg_write ? cfg_data : mode_reg;
        ovf_next       = ovf_reg;
        step_next      = step_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        dvd_next       = dvd_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dz_next        = dz_reg;
        sat_next       = sat_reg;
        res_next       = res_reg;
        for (int i = 0; i < 4; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (hit[i])
                    begin
                        cnt_next[i] = cnt_inc[i];
                        if (cnt_inc[i] == COUNT_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                if (in_xfer && in_data.last_symbol)
                begin
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                // pick operands, clear the counts for the next sequence
                dvd_next  = {(mode_reg ? sum_gc : sum_at), FRACTION_BITS'(0)};
                den_next  = mode_reg ? sum_all : DENW'(sum_gc);
                rem_next  = '0;
                dz_next   = mode_reg ? (sum_all == '0) : (sum_gc == '0);
                sat_next  = ovf_reg;
                step_next = STEPW'(DIVW);
                ovf_next  = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    cnt_next[i] = '0;
                end
                state_next = (mode_reg ? (sum_all == '0) : (sum_gc == '0)) ? ST_DONE : ST_DIV;
            end

            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_diff[DENW-1:0] : rem_trial[DENW-1:0];
                dvd_next  = {dvd_reg[DIVW-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == STEPW'(1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hand the result over once the output register is free
                if (slot_free)
                begin
                    res_next.divisor_zero = dz_reg;
                    res_next.saturated    = sat_reg || (clip && !dz_reg);
                    if (dz_reg)
                    begin
                        res_next.ratio = '0;
                    end
                    else if (clip)
                    begin
                        res_next.ratio = '1;
                    end
                    else
                    begin
                        res_next.ratio = quot_ext[RATIO_BITS-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            ovf_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ovf_reg       <= ovf_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        dz_reg  <= dz_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    // sequencer stays one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // a zero divisor always reports a zero ratio
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divisor_zero |-> out_data.ratio == '0)
        else $error("divisor_zero result with nonzero ratio");

    // counts and overflow are cleared once the operands are taken
    a_setup_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |=> cnt_reg[0] == '0 && cnt_reg[1] == '0 &&
                                  cnt_reg[2] == '0 && cnt_reg[3] == '0 && !ovf_reg)
        else $error("counts not cleared after setup");

    // the divider runs only with a nonzero denominator
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0 && !dz_reg)
        else $error("divide step with zero denominator");
`endif

endmodule : gc_content_ratio_top

`default_nettype wire
